// ----- hdl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the PPM pixel serializer.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int CHAN_W        = 16;
    localparam int BCD_W         = 20;
    localparam int LINE_W        = 7;
    localparam int PPS_QUEUE_DEPTH = 2;

    localparam logic [7:0] LINE_LIMIT = 8'd70;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_SP   = 8'h20;
    localparam logic [7:0] ASCII_LF   = 8'h0A;

    localparam logic [0:0] CFG_BINARY_MODE = 1'b0;
    localparam logic [0:0] CFG_MAX_VALUE   = 1'b1;

    // one pixel, classified and converted, ready for byte emission
    typedef struct packed {
        logic                          binary;
        logic                          wide;
        logic [2:0]                    digits;
        logic                          brk;
        logic [2:0][CHAN_W-1:0]        chan;
        logic [2:0][BCD_W-1:0]         bcd;
    } pps_job_t;

endpackage

// ----- hdl/pps_front.sv -----
// ----------------------------------------------------------------------------
// pps_front
// Accepts pixels, clamps channels, does line accounting and converts each
// channel to BCD in a two-stage double-dabble pipeline.
// ----------------------------------------------------------------------------
module pps_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   binary_mode,
    input  logic [15:0]            max_value,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [15:0]            s_red,
    input  logic [15:0]            s_green,
    input  logic [15:0]            s_blue,
    output logic                   job_valid,
    input  logic                   job_ready,
    output pps_pkg::pps_job_t      job
);
    import pps_pkg::*;

    function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] bcd_in,
                                                 input logic [7:0] bits);
        logic [BCD_W-1:0] b;
        b = bcd_in;
        for (int i = 7; i >= 0; i--) begin
            for (int n = 0; n < BCD_W / 4; n++) begin
                if (b[4*n +: 4] >= 4'd5) begin
                    b[4*n +: 4] = b[4*n +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], bits[i]};
        end
        return b;
    endfunction

    logic        va_reg, vb_reg, vc_reg;
    pps_job_t    ja_reg, jb_reg, jc_reg;
    pps_job_t    ja_next, jb_next, jc_next;
    logic        en_a, en_b, en_c;
    logic [LINE_W-1:0] line_chars_reg, line_chars_next;
    logic [2:0]  digits;
    logic        wide;
    logic [4:0]  cnt, pw;
    logic [7:0]  line_sum;
    logic        brk;
    logic [2:0][CHAN_W-1:0] raw;

    assign en_c    = !vc_reg || job_ready;
    assign en_b    = !vb_reg || en_c;
    assign en_a    = !va_reg || en_b;
    assign s_ready = en_a;

    assign job_valid = vc_reg;
    assign job       = jc_reg;

    assign raw = {s_blue, s_green, s_red};

    always_comb begin
        if (max_value >= 16'd10000) begin
            digits = 3'd5;
        end else if (max_value >= 16'd1000) begin
            digits = 3'd4;
        end else if (max_value >= 16'd100) begin
            digits = 3'd3;
        end else if (max_value >= 16'd10) begin
            digits = 3'd2;
        end else begin
            digits = 3'd1;
        end
        wide = max_value > 16'd255;
        if (binary_mode) begin
            cnt = wide ? 5'd6 : 5'd3;
            pw  = wide ? 5'd2 : 5'd1;
        end else begin
            cnt = 5'({2'b00, digits} + 5'd1) * 5'd3;
            pw  = cnt;
        end
        line_sum        = {1'b0, line_chars_reg} + {3'b000, pw};
        brk             = line_sum > LINE_LIMIT;
        line_chars_next = (brk ? '0 : line_chars_reg) + {2'b00, cnt};

        ja_next        = '0;
        ja_next.binary = binary_mode;
        ja_next.wide   = wide;
        ja_next.digits = digits;
        ja_next.brk    = brk;
        for (int c = 0; c < 3; c++) begin
            ja_next.chan[c] = (raw[c] > max_value) ? max_value : raw[c];
        end

        jb_next = ja_reg;
        jc_next = jb_reg;
        for (int c = 0; c < 3; c++) begin
            jb_next.bcd[c] = dabble8('0, ja_reg.chan[c][15:8]);
            jc_next.bcd[c] = dabble8(jb_reg.bcd[c], jb_reg.chan[c][7:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
            line_chars_reg <= '0;
        end else begin
            if (en_a) begin
                va_reg <= s_valid;
            end
            if (en_b) begin
                vb_reg <= va_reg;
            end
            if (en_c) begin
                vc_reg <= vb_reg;
            end
            if (s_valid && en_a) begin
                line_chars_reg <= line_chars_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            ja_reg <= ja_next;
        end
        if (en_b) begin
            jb_reg <= jb_next;
        end
        if (en_c) begin
            jc_reg <= jc_next;
        end
    end

endmodule

// ----- hdl/pps_queue.sv -----
// ----------------------------------------------------------------------------
// pps_queue
// Small FIFO of converted pixels between the front and back ends.
// ----------------------------------------------------------------------------
module pps_queue #(
    parameter int QUEUE_DEPTH = pps_pkg::PPS_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pps_pkg::pps_job_t      in_job,
    output logic                   out_valid,
    input  logic                   out_pop,
    output pps_pkg::pps_job_t      out_job
);
    import pps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    pps_job_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready  = count_reg != CNT_FULL;
    assign out_valid = count_reg != '0;
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ----- hdl/pps_back.sv -----
// ----------------------------------------------------------------------------
// pps_back
// Walks one queued pixel byte by byte into a registered output word.
// ----------------------------------------------------------------------------
module pps_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   job_valid,
    output logic                   job_pop,
    input  pps_pkg::pps_job_t      job,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_last_byte
);
    import pps_pkg::*;

    logic [1:0]       ch_reg;
    logic [2:0]       pos_reg;
    logic             m_valid_reg, m_last_reg;
    logic [7:0]       m_byte_reg;
    logic             emit, last;
    logic [2:0]       end_pos, j;
    logic [7:0]       cur_byte;
    logic [CHAN_W-1:0] chan_sel;
    logic [BCD_W-1:0] bcd_sel, bcd_sh;

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_last_byte = m_last_reg;

    always_comb begin
        chan_sel = job.chan[ch_reg];
        bcd_sel  = job.bcd[ch_reg];
        j        = job.digits - 3'd1 - pos_reg;
        bcd_sh   = bcd_sel >> {j, 2'b00};
        if (job.binary) begin
            end_pos = job.wide ? 3'd1 : 3'd0;
            if (job.wide && pos_reg == 3'd0) begin
                cur_byte = chan_sel[15:8];
            end else begin
                cur_byte = chan_sel[7:0];
            end
        end else begin
            end_pos = job.digits;
            if (pos_reg == job.digits) begin
                cur_byte = (ch_reg == 2'd2 && job.brk) ? ASCII_LF : ASCII_SP;
            end else if (j != 3'd0 && bcd_sh == '0) begin
                cur_byte = ASCII_SP;
            end else begin
                cur_byte = ASCII_ZERO + {4'h0, bcd_sh[3:0]};
            end
        end
        last    = (ch_reg == 2'd2) && (pos_reg == end_pos);
        emit    = job_valid && (!m_valid_reg || m_ready);
        job_pop = emit && last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ch_reg      <= '0;
            pos_reg     <= '0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit) begin
                if (pos_reg == end_pos) begin
                    pos_reg <= '0;
                    ch_reg  <= last ? 2'd0 : ch_reg + 2'd1;
                end else begin
                    pos_reg <= pos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg <= cur_byte;
            m_last_reg <= last;
        end
    end

endmodule

// ----- hdl/ppm_pixel_serializer_core.sv -----
// ----------------------------------------------------------------------------
// ppm_pixel_serializer_core
// RGB pixel to PPM body byte stream, text or binary.
// ----------------------------------------------------------------------------
// One pixel is accepted per word on s_*, and its bytes leave one per cycle on
// m_* while m_ready is not stalling them: 3 or 6 bytes per pixel in binary
// mode, 3 * (digits + 1) bytes (6 to 18) in text mode. The front end clamps,
// keeps the line count and converts to BCD in a three-stage pipeline; bytes
// leave through the queue and an output register. A queue of QUEUE_DEPTH
// pixels lets the front keep taking pixels while the output stalls. The user
// must write cfg_* configuration only while idle; this is not enforced.
module ppm_pixel_serializer_core #(
    parameter int QUEUE_DEPTH = pps_pkg::PPS_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_red,
    input  logic [15:0] s_green,
    input  logic [15:0] s_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_byte
);
    import pps_pkg::*;

    logic        binary_mode_reg;
    logic [15:0] max_value_reg;
    logic        f_valid, f_ready, q_valid, q_pop;
    pps_job_t    f_job, q_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binary_mode_reg <= 1'b0;
            max_value_reg   <= 16'd255;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BINARY_MODE: binary_mode_reg <= cfg_data[0];
                CFG_MAX_VALUE:   max_value_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    pps_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .binary_mode (binary_mode_reg),
        .max_value   (max_value_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .job_valid   (f_valid),
        .job_ready   (f_ready),
        .job         (f_job)
    );

    pps_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_job   (q_job)
    );

    pps_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (q_valid),
        .job_pop     (q_pop),
        .job         (q_job),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

// ----- hdl/pps_checker.sv -----
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks for the PPM pixel serializer, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last_byte
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid right after reset");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_byte))
        else $error("stalled output word changed");

endmodule

bind ppm_pixel_serializer_core pps_checker u_pps_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_last_byte (m_last_byte)
);
